>>> src/ffic_pkg.sv
package ffic_pkg;

	localparam logic [1:0] OP_F2X = 2'd0;
	localparam logic [1:0] OP_X2F = 2'd1;
	localparam logic [1:0] OP_I2X = 2'd2;
	localparam logic [1:0] OP_X2I = 2'd3;

	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] operand;
	} ffic_in_t;

	typedef struct packed {
		logic [31:0] result;
		logic        saturated;
	} ffic_out_t;

endpackage

>>> src/ffic_core.sv
module ffic_core
	import ffic_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  ffic_in_t  item,
	output ffic_out_t res
);

	localparam int SHW = 10;

	logic        f_neg, f_over, f_sat;
	logic [7:0]  f_ex;
	logic [23:0] f_sig;
	logic signed [SHW-1:0] f_sh;
	logic [SHW-1:0] f_n;
	logic [32:0] f_q;
	logic [23:0] f_rem, f_half;
	logic [31:0] f_res;

	logic        x_neg;
	logic [31:0] x_m;
	logic [4:0]  x_p;
	logic [4:0]  x_s;
	logic [31:0] x_rem, x_half;
	logic [24:0] x_sig;
	logic [8:0]  x_e;
	logic [31:0] x_res;

	logic signed [32+FRACTION_BITS:0] i_prod;

	always_comb begin
		f_neg = item.operand[31];
		f_ex = item.operand[30:23];
		f_over = 1'b0;
		f_sat = 1'b0;
		f_q = '0;
		f_rem = '0;
		f_half = '0;
		f_n = '0;
		if (f_ex == 8'd0) begin
			f_sig = {1'b0, item.operand[22:0]};
			f_sh = SHW'(1 - 150 + FRACTION_BITS);
		end else begin
			f_sig = {1'b1, item.operand[22:0]};
			f_sh = $signed({2'b00, f_ex}) - SHW'(150 - FRACTION_BITS);
		end
		if (f_sh >= 0) begin
			if (f_sh > 8)
				f_over = 1'b1;
			else
				f_q = 33'(f_sig) << f_sh[3:0];
		end else begin
			f_n = SHW'(-f_sh);
			if (f_n <= 24) begin
				f_rem = f_sig & 24'((25'd1 << f_n[4:0]) - 25'd1);
				f_half = 24'(25'd1 << (f_n[4:0] - 5'd1));
				f_q = 33'(f_sig >> f_n[4:0]);
				if (f_rem > f_half)
					f_q = f_q + 33'd1;
			end
		end
		if (f_ex == 8'hFF) begin
			f_sat = 1'b1;
			f_res = (item.operand[22:0] != 0 || !f_neg) ? POS_LIMIT : NEG_LIMIT;
		end else if (f_neg) begin
			if (f_over || f_q > 33'(NEG_LIMIT)) begin
				f_sat = 1'b1;
				f_res = NEG_LIMIT;
			end else
				f_res = 32'd0 - f_q[31:0];
		end else begin
			if (f_over || f_q > 33'(POS_LIMIT)) begin
				f_sat = 1'b1;
				f_res = POS_LIMIT;
			end else
				f_res = f_q[31:0];
		end
	end

	always_comb begin
		x_neg = item.operand[31];
		x_m = x_neg ? 32'd0 - item.operand : item.operand;
		x_p = '0;
		for (int i = 1; i < 32; i++)
			if (x_m[i])
				x_p = 5'(i);
		x_s = '0;
		x_rem = '0;
		x_half = '0;
		x_e = 9'(x_p) - 9'(FRACTION_BITS) + 9'd127;
		if (x_p <= 5'd23)
			x_sig = 25'(x_m << (5'd23 - x_p));
		else begin
			x_s = x_p - 5'd23;
			x_rem = x_m & ((32'd1 << x_s) - 32'd1);
			x_half = 32'd1 << (x_s - 5'd1);
			x_sig = 25'(x_m >> x_s);
			if (x_rem > x_half || (x_rem == x_half && x_sig[0]))
				x_sig = x_sig + 25'd1;
			if (x_sig[24]) begin
				x_sig = x_sig >> 1;
				x_e = x_e + 9'd1;
			end
		end
		x_res = (x_m == 0) ? 32'd0 : {x_neg, x_e[7:0], x_sig[22:0]};
	end

	assign i_prod = $signed({{FRACTION_BITS{item.operand[31]}}, item.operand, 1'b0})
		<<< (FRACTION_BITS - 1);

	always_comb begin
		res.saturated = 1'b0;
		case (item.op)
			OP_F2X: begin
				res.result = f_res;
				res.saturated = f_sat;
			end
			OP_X2F: res.result = x_res;
			OP_I2X: begin
				if (i_prod > $signed({{(FRACTION_BITS+1){1'b0}}, POS_LIMIT})) begin
					res.result = POS_LIMIT;
					res.saturated = 1'b1;
				end else if (i_prod < $signed({{(FRACTION_BITS+1){1'b1}}, NEG_LIMIT})) begin
					res.result = NEG_LIMIT;
					res.saturated = 1'b1;
				end else
					res.result = i_prod[31:0];
			end
			OP_X2I: res.result = 32'($signed(item.operand) >>> FRACTION_BITS);
			default: res.result = '0;
		endcase
	end

endmodule

>>> src/float_fixed_int_converter.sv
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall   | ffic_in_t  (op, operand)
// out     | output    | out_valid/out_stall | ffic_out_t (result, saturated)
//
// Each transaction is registered at the input, converted by one pass of
// combinational logic, and held in a result register; one transaction per
// cycle is sustained while the output is not stalled. The result register
// and the input register form a pipeline that advances whenever the result
// slot is empty or being taken. Reset clears both valid bits.
module float_fixed_int_converter
	import ffic_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ffic_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output ffic_out_t out_data
);

	logic      valid_s1;
	ffic_in_t  item_s1;
	ffic_out_t res_c;
	logic      adv_s2, adv_s1;

	// The result stage moves when it is empty or its content is taken.
	assign adv_s2 = !out_valid || !out_stall;
	// The input stage moves when it is empty or hands off to the result stage.
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid)
			item_s1 <= in_data;
		if (adv_s2 && valid_s1)
			out_data <= res_c;
	end

	ffic_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
		.item(item_s1),
		.res (res_c)
	);

	// A stalled result keeps its valid bit.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// Input is refused only when both stages are full.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("spurious input stall");

	// A filled input stage reaches the output the next cycle when free.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> out_valid)
		else $error("transaction lost between stages");

endmodule

>>> dv/ffic_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts each result from the
// accepted input transaction, and compares in order.
module ffic_checker
	import ffic_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  ffic_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  ffic_out_t out_data,
	output int        errors,
	output int        pending,
	output int        results_seen
);

	ffic_out_t expected_q[$];

	function automatic ffic_out_t float_to_q(logic [31:0] bits);
		ffic_out_t r;
		logic [7:0] ex;
		logic [63:0] sig, q, rem, half;
		int sh, n;
		logic over;
		r.saturated = 1'b0;
		over = 1'b0;
		ex = bits[30:23];
		if (ex == 8'hFF) begin
			r.saturated = 1'b1;
			r.result = (bits[22:0] != 0 || !bits[31]) ? POS_LIMIT : NEG_LIMIT;
			return r;
		end
		if (ex == 0) begin
			sig = {41'd0, bits[22:0]};
			sh = 1 - 150 + FRACTION_BITS;
		end else begin
			sig = {40'd0, 1'b1, bits[22:0]};
			sh = int'(ex) - 150 + FRACTION_BITS;
		end
		if (sh >= 0) begin
			if (sh > 8) begin
				over = 1'b1;
				q = 0;
			end else begin
				q = sig << sh;
			end
		end else begin
			n = -sh;
			if (n > 24) begin
				q = 0;
			end else begin
				rem = sig & ((64'd1 << n) - 1);
				half = 64'd1 << (n - 1);
				q = sig >> n;
				if (rem > half)
					q = q + 1;
			end
		end
		if (bits[31]) begin
			if (over || q > 64'h8000_0000) begin
				r.saturated = 1'b1;
				r.result = NEG_LIMIT;
			end else begin
				r.result = 32'd0 - q[31:0];
			end
		end else if (over || q > 64'h7FFF_FFFF) begin
			r.saturated = 1'b1;
			r.result = POS_LIMIT;
		end else begin
			r.result = q[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] q_to_float(logic [31:0] w);
		logic [31:0] m, sig, rem, half;
		int p, e, s;
		m = w[31] ? 32'd0 - w : w;
		if (m == 0)
			return 32'd0;
		p = 31;
		while (!m[p])
			p--;
		e = p - FRACTION_BITS;
		if (p <= 23) begin
			sig = m << (23 - p);
		end else begin
			s = p - 23;
			rem = m & ((32'd1 << s) - 1);
			half = 32'd1 << (s - 1);
			sig = m >> s;
			if (rem > half || (rem == half && sig[0]))
				sig = sig + 1;
			if (sig[24]) begin
				sig = sig >> 1;
				e++;
			end
		end
		return {w[31], 8'(e + 127), sig[22:0]};
	endfunction

	function automatic ffic_out_t convert(ffic_in_t t);
		ffic_out_t r;
		logic signed [63:0] prod;
		r.saturated = 1'b0;
		case (t.op)
			OP_F2X: r = float_to_q(t.operand);
			OP_X2F: r.result = q_to_float(t.operand);
			OP_I2X: begin
				prod = 64'(signed'(t.operand)) <<< FRACTION_BITS;
				if (prod > 64'sh7FFF_FFFF) begin
					r.saturated = 1'b1;
					r.result = POS_LIMIT;
				end else if (prod < -64'sh8000_0000) begin
					r.saturated = 1'b1;
					r.result = NEG_LIMIT;
				end else begin
					r.result = prod[31:0];
				end
			end
			default: r.result = 32'(signed'(t.operand) >>> FRACTION_BITS);
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ffic_out_t exp_r;
		logic bad;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(convert(in_data));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					$error("unexpected result transaction %h", out_data);
					errors <= errors + 1;
				end else begin
					exp_r = expected_q.pop_front();
					bad = 1'b0;
					if (out_data.result !== exp_r.result) begin
						$error("result: expected %h actual %h", exp_r.result, out_data.result);
						bad = 1'b1;
					end
					if (out_data.saturated !== exp_r.saturated) begin
						$error("saturated: expected %b actual %b", exp_r.saturated,
							out_data.saturated);
						bad = 1'b1;
					end
					if (bad)
						errors <= errors + 1;
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

// Top of the converter testbench. It drives input transactions with random
// gaps, stalls the result channel at random (including one long hold-off
// that backs the pipeline up into the input), and reports the verdict from
// the checker's failure count.
module testbench;
	import ffic_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	ffic_in_t  in_data;
	logic      out_valid;
	logic      out_stall;
	ffic_out_t out_data;
	int        errors;
	int        pending;
	int        results_seen;
	int        sent;
	logic      hold_off;

	float_fixed_int_converter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	ffic_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap length: mostly zero or short, now and then long.
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Operands aimed at the interesting regions of each operation.
	function automatic logic [31:0] pick_operand(logic [1:0] op);
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
			0: return v;
			1: begin
				// Float exponents around the representable Q24.8 range,
				// with rounding-relevant low mantissa bits.
				v[30:23] = 8'($urandom_range(100, 160));
				return v;
			end
			2: begin
				v[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'hFF;
				if ($urandom_range(0, 1))
					v[22:0] = 23'd0;
				return v;
			end
			3: return 32'(signed'($urandom_range(0, 600)) - 300) << $urandom_range(0, 8);
			4: return {{9{v[31]}}, v[22:0]};
			default: return v >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send(logic [1:0] op, logic [31:0] operand);
		int g;
		g = gap_len();
		repeat (g) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.op <= op;
		in_data.operand <= operand;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Receiver: random stalls, one long hold-off while the sender keeps going.
	initial begin
		int g;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (60) @(negedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end else begin
				g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				if (g > 0) begin
					out_stall <= 1'b1;
					repeat (g - 1) @(negedge clk);
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [31:0] edge_vals[$];
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		hold_off = 1'b0;
		sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zeros, limits, infinities, NaN, negative zero,
		// subnormals, halfway ties and the float overflow boundary.
		edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001,
			32'h3B00_0000, 32'h3B40_0000, 32'hBB40_0000, 32'h4B00_0000,
			32'h4EFF_FFFF, 32'hCF00_0000, 32'h0080_0000, 32'h0000_0100,
			32'h007F_FFFF, 32'hFF80_0000};
		foreach (edge_vals[i])
			send(2'(i % 4), edge_vals[i]);
		send(OP_F2X, 32'h4F00_0000);
		send(OP_X2F, 32'hFFFF_FF80);
		send(OP_X2F, 32'h0100_0001);
		send(OP_I2X, 32'h0080_0000);
		send(OP_I2X, 32'hFF7F_FFFF);
		send(OP_X2I, 32'h8000_0000);

		// Random part, with one long receiver hold-off in the middle.
		n = 0;
		while (n < 1800) begin
			logic [1:0] op;
			op = 2'($urandom_range(0, 3));
			if (n == 600)
				hold_off = 1'b1;
			if (n == 640)
				hold_off = 1'b0;
			send(op, pick_operand(op));
			n++;
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d transactions over all four conversions, %0d results checked,",
			sent, results_seen);
		$display("including special floats, saturation, ties and a long output stall.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
